[hw/rtl/hmac_sha1_96_icv_defines.svh]
// Assertion macros shared by the HMAC-SHA1-96 RTL.
// No dependencies.
`ifndef HMAC_SHA1_96_ICV_DEFINES_SVH
`define HMAC_SHA1_96_ICV_DEFINES_SVH
`ifndef SYNTHESIS
`define HSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/hsi_pkg.sv]
// Package for the HMAC-SHA1-96 ICV engine: queue entry type, states, SHA-1 constants.
// No dependencies.
package hsi_pkg;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_MID  = 2'd1;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd2;

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;

    localparam logic [159:0] SHA_INIT =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // One queued byte from the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       hash;   // byte enters the hash
        logic       first;  // first byte of the message
        logic       last;
        logic       dir;
    } q_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_IN,
        ST_PAD_OUT,
        ST_MSG,
        ST_FIN_PAD,
        ST_FIN_CMP,
        ST_OUTER,
        ST_OUT_CMP,
        ST_RESULT
    } back_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20)      round_k = 32'h5A827999;
        else if (t < 7'd40) round_k = 32'h6ED9EBA1;
        else if (t < 7'd60) round_k = 32'h8F1BBCDC;
        else                round_k = 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)      round_f = (b & c) | (~b & d);
        else if (t < 7'd40) round_f = b ^ c ^ d;
        else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else                round_f = b ^ c ^ d;
    endfunction
endpackage

[hw/rtl/hsi_sha1_core.sv]
// SHA-1 compression unit: one round per cycle over a 16-word rolling schedule.
// Depends on hsi_pkg and the defines header.
`include "hmac_sha1_96_icv_defines.svh"
module hsi_sha1_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [159:0] h_in,
    input  logic [511:0] blk,     // word 0 in top bits
    output logic         busy,
    output logic         done,
    output logic [159:0] h_out
);
    logic [6:0]   t_reg, t_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [511:0] w_reg, w_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [159:0] h_reg, h_next;
    logic [31:0]  wt, wnew, tmp;

    always_comb begin
        wt   = w_reg[511:480];
        wnew = hsi_pkg::rotl(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416]
                             ^ w_reg[511:480], 1);
        tmp  = hsi_pkg::rotl(a_reg, 5) + hsi_pkg::round_f(t_reg, b_reg, c_reg, d_reg)
               + e_reg + hsi_pkg::round_k(t_reg) + wt;
        t_next = t_reg; busy_next = busy_reg; done_next = 1'b0; w_next = w_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        h_next = h_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1; t_next = '0; w_next = blk; h_next = h_in;
            a_next = h_in[159:128]; b_next = h_in[127:96]; c_next = h_in[95:64];
            d_next = h_in[63:32];   e_next = h_in[31:0];
        end else if (busy_reg) begin
            w_next = {w_reg[479:0], wnew};
            e_next = d_reg; d_next = c_reg; c_next = hsi_pkg::rotl(b_reg, 30);
            b_next = a_reg; a_next = tmp;
            t_next = t_reg + 7'd1;
            if (t_reg == 7'd79) begin
                busy_next = 1'b0; done_next = 1'b1;
                h_next = {h_reg[159:128] + tmp, h_reg[127:96] + a_reg,
                          h_reg[95:64] + hsi_pkg::rotl(b_reg, 30),
                          h_reg[63:32] + c_reg, h_reg[31:0] + d_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; t_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; t_reg <= t_next;
        end
        w_reg <= w_next; h_reg <= h_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next; e_reg <= e_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign h_out = h_reg;

    `HSI_ASSERT_NEXT(a_done_end, aclk, aresetn, busy_reg && t_reg == 7'd79, done_reg)
    `HSI_ASSERT_IMPL(a_done_idle, aclk, aresetn, done_reg, !busy_reg)
    `HSI_ASSERT_IMPL(a_round_rng, aclk, aresetn, busy_reg, t_reg < 7'd80)
endmodule

[hw/rtl/hsi_front.sv]
// Front end: tracks header/payload counts and marks which bytes enter the hash.
// Depends on hsi_pkg.
module hsi_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  is_header,
    input  logic [15:0]           start_offset,
    input  logic                  direction_out,
    input  logic                  last_byte,
    output logic                  q_valid,
    input  logic                  q_ready,
    output hsi_pkg::q_entry_t     q_data
);
    localparam logic [OFFSET_BITS-1:0] CMAX = '1;
    logic                   open_reg, open_next;
    logic [OFFSET_BITS-1:0] hcnt_reg, hcnt_next, pidx_reg, pidx_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next, off_use, eff;
    logic                   dir_reg, dir_next, dir_use;
    logic [OFFSET_BITS-1:0] hcnt_use, pidx_use;
    logic                   acc;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign acc      = in_valid && q_ready;

    always_comb begin
        off_use  = open_reg ? off_reg
                 : OFFSET_BITS'({{(OFFSET_BITS > 16 ? OFFSET_BITS - 16 : 1){1'b0}}, start_offset});
        dir_use  = open_reg ? dir_reg : direction_out;
        hcnt_use = open_reg ? hcnt_reg : '0;
        pidx_use = open_reg ? pidx_reg : '0;
        eff      = (off_use != '0) ? off_use : hcnt_use;
        q_data.data  = data_byte;
        q_data.first = !open_reg;
        q_data.last  = last_byte;
        q_data.dir   = dir_use;
        q_data.hash  = is_header || (pidx_use >= eff);
        open_next = open_reg; hcnt_next = hcnt_reg; pidx_next = pidx_reg;
        off_next = off_reg; dir_next = dir_reg;
        if (acc) begin
            off_next = off_use; dir_next = dir_use;
            hcnt_next = hcnt_use; pidx_next = pidx_use;
            if (is_header) begin
                if (hcnt_use != CMAX) hcnt_next = hcnt_use + 1'b1;
            end else if (pidx_use != CMAX) begin
                pidx_next = pidx_use + 1'b1;
            end
            open_next = !last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0; hcnt_reg <= '0; pidx_reg <= '0; off_reg <= '0; dir_reg <= 1'b0;
        end else begin
            open_reg <= open_next; hcnt_reg <= hcnt_next; pidx_reg <= pidx_next;
            off_reg <= off_next; dir_reg <= dir_next;
        end
    end
endmodule

[hw/rtl/hsi_queue.sv]
// Short FIFO between the front end and the hash back end.
// Depends on hsi_pkg.
module hsi_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  hsi_pkg::q_entry_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output hsi_pkg::q_entry_t rd_data
);
    hsi_pkg::q_entry_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

[hw/rtl/hsi_back.sv]
// Back end: builds pad hashes, packs bytes into blocks, finalizes inner and outer hash.
// Depends on hsi_pkg, hsi_sha1_core and the defines header.
`include "hmac_sha1_96_icv_defines.svh"
module hsi_back #(
    parameter int KEY_BYTES = 20,
    parameter int ICV_BYTES = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [159:0]      key,       // byte 0 in top bits
    input  logic              key_wr,
    input  logic              q_valid,
    output logic              q_ready,
    input  hsi_pkg::q_entry_t q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       icv_upper,
    output logic [31:0]       icv_lower,
    output logic              ack_outbound
);
    hsi_pkg::back_state_t st_reg, st_next;
    logic         pv_reg, pv_next;
    logic [159:0] ih_reg, ih_next, oh_reg, oh_next, cv_reg, cv_next;
    logic [511:0] buf_reg, buf_next;
    logic [31:0]  len_reg, len_next;
    logic         dir_reg, dir_next, lastp_reg, lastp_next;
    logic [63:0]  up_reg, up_next;
    logic [31:0]  lo_reg, lo_next;
    logic         start;
    logic [159:0] h_in, h_out;
    logic [511:0] blk, kpad, ipad, opad, bmask;
    logic         busy, done;
    logic [5:0]   pos;
    logic [159:0] dg;
    logic [63:0]  bits;

    hsi_sha1_core u_core (.aclk, .aresetn, .start, .h_in, .blk, .busy, .done, .h_out);

    always_comb begin
        for (int i = 0; i < 20; i++)
            kpad[511-8*i -: 8] = (i < KEY_BYTES) ? key[159-8*i -: 8] : 8'h00;
        kpad[351:0] = '0;
        ipad = kpad ^ {16{hsi_pkg::IPAD_WORD}};
        opad = kpad ^ {16{hsi_pkg::OPAD_WORD}};
    end

    assign pos  = len_reg[5:0];
    assign bits = ({32'd0, len_reg} + 64'd64) << 3;
    assign m_valid = st_reg == hsi_pkg::ST_RESULT;
    assign icv_upper = up_reg;
    assign icv_lower = lo_reg;
    assign ack_outbound = dir_reg;

    always_comb begin
        st_next = st_reg; pv_next = pv_reg && !key_wr;
        ih_next = ih_reg; oh_next = oh_reg; cv_next = cv_reg; buf_next = buf_reg;
        len_next = len_reg; dir_next = dir_reg; lastp_next = lastp_reg;
        up_next = up_reg; lo_next = lo_reg;
        q_ready = 1'b0; start = 1'b0; h_in = hsi_pkg::SHA_INIT; blk = ipad;
        bmask = '0; dg = '0;
        unique case (st_reg)
            hsi_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_data.first && !pv_reg) begin
                        start = 1'b1; st_next = hsi_pkg::ST_PAD_IN;
                    end else begin
                        st_next = hsi_pkg::ST_MSG;
                    end
                end
            end
            hsi_pkg::ST_PAD_IN: if (done) begin
                ih_next = h_out; start = 1'b1; blk = opad; st_next = hsi_pkg::ST_PAD_OUT;
            end
            hsi_pkg::ST_PAD_OUT: if (done) begin
                oh_next = h_out; pv_next = !key_wr; st_next = hsi_pkg::ST_MSG;
            end
            hsi_pkg::ST_MSG: begin
                q_ready = 1'b1;
                if (q_data.first) begin
                    cv_next = ih_reg; len_next = '0; dir_next = q_data.dir;
                end
                lastp_next = q_data.last;
                st_next = q_data.last ? hsi_pkg::ST_FIN_PAD : hsi_pkg::ST_IDLE;
                if (q_data.hash) begin
                    bmask = {8'hFF, 504'd0} >> ({3'd0, (q_data.first ? 6'd0 : pos)} << 3);
                    buf_next = (buf_reg & ~bmask) | (bmask & ({q_data.data, 504'd0}
                               >> ({3'd0, (q_data.first ? 6'd0 : pos)} << 3)));
                    len_next = (q_data.first ? 32'd0 : len_reg) + 32'd1;
                    if ((q_data.first ? 6'd0 : pos) == 6'd63) begin
                        start = 1'b1; h_in = q_data.first ? ih_reg : cv_reg; blk = buf_next;
                        st_next = hsi_pkg::ST_FIN_PAD; // wait for compress
                        lastp_next = q_data.last;
                    end
                end
                if (start) st_next = hsi_pkg::ST_FIN_CMP;
            end
            hsi_pkg::ST_FIN_CMP: if (done) begin
                // block compress during the message
                cv_next = h_out;
                st_next = lastp_reg ? hsi_pkg::ST_FIN_PAD : hsi_pkg::ST_IDLE;
            end
            hsi_pkg::ST_FIN_PAD: begin
                // append 0x80 and zeros; length in this block if room remains
                bmask = {512{1'b1}} >> ({3'd0, pos} << 3);
                buf_next = (buf_reg & ~bmask) | ({8'h80, 504'd0} >> ({3'd0, pos} << 3));
                if (pos < 6'd56) buf_next[63:0] = bits;
                start = 1'b1; h_in = cv_reg; blk = buf_next;
                len_next = (pos < 6'd56) ? len_reg : 32'd0;
                lastp_next = pos < 6'd56;
                st_next = hsi_pkg::ST_OUTER;
                if (pos >= 6'd56) begin
                    // extra all-zero length block follows
                    len_next = len_reg;
                end
            end
            hsi_pkg::ST_OUTER: if (done) begin
                if (!lastp_reg) begin
                    start = 1'b1; h_in = h_out; blk = {448'd0, bits}; lastp_next = 1'b1;
                end else begin
                    start = 1'b1; h_in = oh_reg;
                    blk = {h_out, 32'h80000000, 288'd0, 32'd672};
                    st_next = hsi_pkg::ST_OUT_CMP;
                end
            end
            hsi_pkg::ST_OUT_CMP: if (done) begin
                for (int i = 0; i < 20; i++)
                    dg[159-8*i -: 8] = (i < ICV_BYTES) ? h_out[159-8*i -: 8] : 8'h00;
                up_next = dg[159:96]; lo_next = dg[95:64];
                st_next = hsi_pkg::ST_RESULT;
            end
            hsi_pkg::ST_RESULT: if (m_ready) st_next = hsi_pkg::ST_IDLE;
            default: st_next = hsi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= hsi_pkg::ST_IDLE; pv_reg <= 1'b0; len_reg <= '0;
            dir_reg <= 1'b0; lastp_reg <= 1'b0;
        end else begin
            st_reg <= st_next; pv_reg <= pv_next; len_reg <= len_next;
            dir_reg <= dir_next; lastp_reg <= lastp_next;
        end
        ih_reg <= ih_next; oh_reg <= oh_next; cv_reg <= cv_next; buf_reg <= buf_next;
        up_reg <= up_next; lo_reg <= lo_next;
    end

    `HSI_ASSERT_IMPL(a_start_free, aclk, aresetn, start, !busy)
    `HSI_ASSERT_IMPL(a_no_pop_busy, aclk, aresetn, q_ready, !busy)
    `HSI_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

[hw/rtl/hmac_sha1_96_icv.sv]
// HMAC-SHA1-96 ICV engine, top level. When 56 or more hashed bytes sit in the final block,
// the length needs an extra block; one more block compress runs when the last beat
// completes a 64-byte block. Each byte passes a back end idle check, then a queue pop;
// every 64 hashed bytes add a block compress, and the pad hashes are computed at the
// first message after a key write.
// Reset: aresetn synchronous active low; key zero, pads invalid, idle.
module hmac_sha1_96_icv #(
    parameter int KEY_BYTES   = 20,
    parameter int ICV_BYTES   = 12,
    parameter int OFFSET_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input bytes
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], start_offset[23:8]
    input  logic [1:0]   s_tuser,   // is_header[0], direction_out[1]
    input  logic         s_tlast,   // last_byte
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // icv_upper[63:0], icv_lower[95:64]
    output logic         m_tuser,   // ack_outbound
    // key registers
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [63:0] khi_reg, kmid_reg;
    logic [31:0] klo_reg;
    logic        cfg_wr, key_wr;
    logic        fq_valid, fq_ready, bq_valid, bq_ready;
    hsi_pkg::q_entry_t fq_data, bq_data;
    logic [63:0] icv_upper;
    logic [31:0] icv_lower;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign key_wr    = cfg_wr && (cfg_index == hsi_pkg::CFG_KEY_HIGH
                       || cfg_index == hsi_pkg::CFG_KEY_MID || cfg_index == hsi_pkg::CFG_KEY_LOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            khi_reg <= '0; kmid_reg <= '0; klo_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                hsi_pkg::CFG_KEY_HIGH: khi_reg  <= cfg_data;
                hsi_pkg::CFG_KEY_MID:  kmid_reg <= cfg_data;
                hsi_pkg::CFG_KEY_LOW:  klo_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    hsi_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .data_byte(s_tdata[7:0]), .is_header(s_tuser[0]), .start_offset(s_tdata[23:8]),
        .direction_out(s_tuser[1]), .last_byte(s_tlast),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

    hsi_queue u_queue (
        .aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));

    hsi_back #(.KEY_BYTES(KEY_BYTES), .ICV_BYTES(ICV_BYTES)) u_back (
        .aclk, .aresetn, .key({khi_reg, kmid_reg, klo_reg}), .key_wr,
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .m_valid(m_tvalid), .m_ready(m_tready), .icv_upper, .icv_lower,
        .ack_outbound(m_tuser));

    assign m_tdata = {icv_lower, icv_upper};
endmodule
